@@ sv/ltfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltfc_pkg
// Shared widths, codes and types of the linear truncation facies classifier.
// ----------------------------------------------------------------------------
package ltfc_pkg;

    localparam int MAX_RULES_DEF  = 16;
    localparam int MAX_FIELDS_DEF = 4;

    localparam int CMD_W      = 2;
    localparam int NODE_W     = 4;
    localparam int FIELD_W    = 2;
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int SUM_W      = 34;
    localparam int FACIES_W   = 8;
    localparam int N_GAUSS    = 4;
    localparam int NODES_W    = 5;
    localparam int FIELDS_W   = 3;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [NODES_W-1:0]  NODES_RST  = 5'd0;
    localparam logic [FIELDS_W-1:0] FIELDS_RST = 3'd4;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WEIGHT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RULE     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NODES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELDS = 1'd1;

    // one request as it travels down the rule chain
    typedef struct packed {
        logic [CMD_W-1:0]                  cmd;
        logic [NODE_W-1:0]                 node;
        logic [FIELD_W-1:0]                field;
        logic [SAMPLE_W-1:0]               weight;
        logic [SUM_W-1:0]                  thr;
        logic [FACIES_W-1:0]               rfac;
        logic [N_GAUSS-1:0][SAMPLE_W-1:0]  gauss;
        logic [FACIES_W-1:0]               facies;
    } ltfc_item_t;

    typedef struct packed {
        logic                advance;
        logic [NODES_W-1:0]  nodes_in_use;
        logic [FIELDS_W-1:0] fields_in_use;
    } ltfc_ctrl_t;

endpackage

@@ sv/linear_truncation_facies_classifier_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_truncation_facies_classifier_top
// Plurigaussian facies classifier built as a chain of linear rule cells.
// ----------------------------------------------------------------------------
// Every request (classify, weight write, rule write) walks a chain of
// MAX_RULES rule cells, three register stages per cell (products, sum,
// compare). A result shows on out_valid from the compare register of the
// last cell. A new request is taken every clock; the whole chain holds
// while a result waits with out_stall high, and in_stall follows that hold.
// Writes travel the same chain, so they take effect in request order with
// respect to classifies. A rule must be written before a classify uses it;
// write commands and configuration writes give no result. Configuration is
// to be written only while the chain is empty; the block itself does not
// enforce this.
module linear_truncation_facies_classifier_top #(
    parameter int MAX_RULES  = ltfc_pkg::MAX_RULES_DEF,
    parameter int MAX_FIELDS = ltfc_pkg::MAX_FIELDS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_we,
    input  logic [ltfc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ltfc_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [ltfc_pkg::CMD_W-1:0]            command,
    input  logic [ltfc_pkg::NODE_W-1:0]           node_index,
    input  logic [ltfc_pkg::FIELD_W-1:0]          field_index,
    input  logic signed [ltfc_pkg::SAMPLE_W-1:0]  weight_value,
    input  logic signed [ltfc_pkg::SUM_W-1:0]     threshold_value,
    input  logic [ltfc_pkg::FACIES_W-1:0]         rule_facies,
    input  logic signed [ltfc_pkg::SAMPLE_W-1:0]  gauss_0,
    input  logic signed [ltfc_pkg::SAMPLE_W-1:0]  gauss_1,
    input  logic signed [ltfc_pkg::SAMPLE_W-1:0]  gauss_2,
    input  logic signed [ltfc_pkg::SAMPLE_W-1:0]  gauss_3,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [ltfc_pkg::FACIES_W-1:0]         facies
);

    logic [ltfc_pkg::NODES_W-1:0]  nodes_in_use_reg;
    logic [ltfc_pkg::FIELDS_W-1:0] fields_in_use_reg;

    ltfc_pkg::ltfc_ctrl_t ctrl;
    ltfc_pkg::ltfc_item_t item_head;
    logic                 vld_c  [MAX_RULES+1];
    ltfc_pkg::ltfc_item_t item_c [MAX_RULES+1];
    logic                 advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_in_use_reg  <= ltfc_pkg::NODES_RST;
            fields_in_use_reg <= ltfc_pkg::FIELDS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ltfc_pkg::REG_NODES:  nodes_in_use_reg  <= cfg_data;
                ltfc_pkg::REG_FIELDS: fields_in_use_reg <= cfg_data[ltfc_pkg::FIELDS_W-1:0];
                default: ;
            endcase
        end
    end

    // last cell's stage is the output register
    assign out_valid = vld_c[MAX_RULES] && (item_c[MAX_RULES].cmd == ltfc_pkg::CMD_CLASSIFY);
    assign facies    = item_c[MAX_RULES].facies;
    assign advance   = !(out_valid && out_stall);
    assign in_stall  = !advance;

    always_comb
    begin
        ctrl.advance       = advance;
        ctrl.nodes_in_use  = nodes_in_use_reg;
        ctrl.fields_in_use = fields_in_use_reg;
    end

    always_comb
    begin
        item_head.cmd      = command;
        item_head.node     = node_index;
        item_head.field    = field_index;
        item_head.weight   = weight_value;
        item_head.thr      = threshold_value;
        item_head.rfac     = rule_facies;
        item_head.gauss[0] = gauss_0;
        item_head.gauss[1] = gauss_1;
        item_head.gauss[2] = gauss_2;
        item_head.gauss[3] = gauss_3;
        item_head.facies   = '0;
    end

    assign vld_c[0]  = in_valid;
    assign item_c[0] = item_head;

    for (genvar i = 0; i < MAX_RULES; i++)
    begin : g_cell
        ltfc_cell #(
            .MAX_FIELDS (MAX_FIELDS),
            .CELL_IDX   (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .vld_in   (vld_c[i]),
            .item_in  (item_c[i]),
            .vld_out  (vld_c[i+1]),
            .item_out (item_c[i+1])
        );
    end

endmodule

@@ sv/ltfc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltfc_cell
// One truncation rule: holds its weights, threshold and facies code, and
// runs each passing request through product, sum and compare stages.
// ----------------------------------------------------------------------------
module ltfc_cell #(
    parameter int MAX_FIELDS = ltfc_pkg::MAX_FIELDS_DEF,
    parameter int CELL_IDX   = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ltfc_pkg::ltfc_ctrl_t ctrl,
    input  logic                 vld_in,
    input  ltfc_pkg::ltfc_item_t item_in,
    output logic                 vld_out,
    output ltfc_pkg::ltfc_item_t item_out
);

    logic [ltfc_pkg::SAMPLE_W-1:0]        w_reg [MAX_FIELDS];
    logic [ltfc_pkg::SUM_W-1:0]           thr_reg;
    logic [ltfc_pkg::FACIES_W-1:0]        fac_reg;

    logic                                 s1_vld_reg;
    ltfc_pkg::ltfc_item_t                 s1_item_reg;
    logic [ltfc_pkg::PROD_W-1:0]          prod_reg  [MAX_FIELDS];
    logic [ltfc_pkg::PROD_W-1:0]          prod_next [MAX_FIELDS];
    logic signed [ltfc_pkg::PROD_W-1:0]   prod_full [MAX_FIELDS];

    logic                                 s2_vld_reg;
    ltfc_pkg::ltfc_item_t                 s2_item_reg;
    logic [ltfc_pkg::SUM_W-1:0]           sum_reg;
    logic [ltfc_pkg::SUM_W-1:0]           sum_next;

    logic                                 s3_vld_reg;
    ltfc_pkg::ltfc_item_t                 s3_item_reg;
    ltfc_pkg::ltfc_item_t                 s3_item_next;

    logic wr_weight;
    logic wr_rule;
    logic active;
    logic hit;

    assign wr_weight = vld_in && (item_in.cmd == ltfc_pkg::CMD_WEIGHT)
                       && (32'(item_in.node) == CELL_IDX);
    // threshold/code are read at the compare stage, so written there too
    assign wr_rule   = s2_vld_reg && (s2_item_reg.cmd == ltfc_pkg::CMD_RULE)
                       && (32'(s2_item_reg.node) == CELL_IDX);
    assign active    = 32'(ctrl.nodes_in_use) > CELL_IDX;

    for (genvar f = 0; f < MAX_FIELDS; f++)
    begin : g_mul
        assign prod_full[f] = $signed(item_in.gauss[f]) * $signed(w_reg[f]);
        assign prod_next[f] = (32'(ctrl.fields_in_use) > f) ? prod_full[f] : '0;
    end

    always_comb
    begin
        sum_next = '0;
        for (int f = 0; f < MAX_FIELDS; f++)
        begin
            sum_next = sum_next
                + {{(ltfc_pkg::SUM_W - ltfc_pkg::PROD_W){prod_reg[f][ltfc_pkg::PROD_W-1]}},
                   prod_reg[f]};
        end
    end

    assign hit = active && ($signed(sum_reg) >= $signed(thr_reg));

    always_comb
    begin
        s3_item_next = s2_item_reg;
        if ((s2_item_reg.cmd == ltfc_pkg::CMD_CLASSIFY) && hit)
        begin
            s3_item_next.facies = fac_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            s1_vld_reg <= vld_in;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            s1_item_reg <= item_in;
            s2_item_reg <= s1_item_reg;
            s3_item_reg <= s3_item_next;
            sum_reg     <= sum_next;
            for (int f = 0; f < MAX_FIELDS; f++)
            begin
                prod_reg[f] <= prod_next[f];
                if (wr_weight && (32'(item_in.field) == f))
                begin
                    w_reg[f] <= item_in.weight;
                end
            end
            if (wr_rule)
            begin
                thr_reg <= s2_item_reg.thr;
                fac_reg <= s2_item_reg.rfac;
            end
        end
    end

    assign vld_out  = s3_vld_reg;
    assign item_out = s3_item_reg;

endmodule

@@ sv/ltfc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltfc_checker
// Port-level checks of the classifier top, attached by bind.
// ----------------------------------------------------------------------------
module ltfc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [ltfc_pkg::FACIES_W-1:0]     facies
);

    // a held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(facies))
        else $error("result changed while stalled");

    // input back-pressure only comes from a stalled result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall not tied to output stall");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

bind linear_truncation_facies_classifier_top ltfc_checker u_ltfc_checker (.*);
